/* rtl/core/apvc_pkg.sv */
// Shared widths, codes, types and helper functions of the anchor projection block.
`timescale 1ns / 1ps
`default_nettype none
package apvc_pkg;

  localparam int WORLD_W   = 20;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 36;
  localparam int TRANS_W   = 32;
  localparam int CLIP_W    = 38;
  localparam int DIFF_W    = 21;
  localparam int SQR_W     = 41;
  localparam int D2_W      = 42;
  localparam int SQRT_IN_W = 58;
  localparam int DIST_W    = SQRT_IN_W / 2;
  localparam int ABS_W     = 38;
  localparam int ABSZ_W    = 37;
  localparam int NUMXY_W   = 55;
  localparam int NUMZ_W    = 51;
  localparam int NUMS_W    = 40;
  localparam int DIV_QB    = 23;
  localparam int QS_W      = DIV_QB + 2;
  localparam int VP_W      = 14;
  localparam int CAM_W     = 60;
  localparam int ROW_W     = 64;
  localparam int EDGE_W    = 19;
  localparam int SCR_W     = 21;
  localparam int DEPTH_W   = 16;
  localparam int SCALE_W   = 16;
  localparam int SCR_MAX   = 1048575;
  localparam int SCR_MIN   = -1048576;
  localparam int DEP_MAX   = 32767;
  localparam int DEP_MIN   = -32768;

  localparam logic [DIST_W-1:0]  DIST_MIN  = DIST_W'(66);
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(4096);

  // Input register stages, square root, divider with its check stage, output register.
  localparam int LATENCY = 4 + DIST_W + DIV_QB + 2;

  localparam logic [2:0] CFG_CLIP_X    = 3'd0;
  localparam logic [2:0] CFG_CLIP_Y    = 3'd1;
  localparam logic [2:0] CFG_CLIP_Z    = 3'd2;
  localparam logic [2:0] CFG_CLIP_W    = 3'd3;
  localparam logic [2:0] CFG_CAMERA    = 3'd4;
  localparam logic [2:0] CFG_VP_WIDTH  = 3'd5;
  localparam logic [2:0] CFG_VP_HEIGHT = 3'd6;

  localparam int FLAG_ENABLE      = 0;
  localparam int FLAG_HIDE_BEHIND = 1;
  localparam int FLAG_HIDE_OUT    = 2;
  localparam int FLAG_SCALE       = 3;

  typedef enum logic [2:0] {
    ST_DISABLED  = 3'd0,
    ST_NO_CAMERA = 3'd1,
    ST_BEHIND    = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_VISIBLE   = 3'd4
  } anchor_state_t;

  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [3:0]         flags;
    logic [15:0]        margin;
    logic [19:0]        refd;
    logic [15:0]        s0;
    logic [15:0]        s1;
  } fields_t;

  typedef struct packed {
    anchor_state_t state;
    logic          render;
    logic          clamp;
    logic          compute;
    logic          scale_en;
    logic          negx;
    logic          negy;
    logic          negz;
  } ctl_t;

  typedef struct packed {
    ctl_t                      ctl;
    logic signed [15:0]        ox;
    logic signed [15:0]        oy;
    logic [15:0]               margin;
    logic signed [EDGE_W-1:0]  hx;
    logic signed [EDGE_W-1:0]  hy;
    logic [15:0]               lo;
    logic [15:0]               hi;
  } side_b_t;

  typedef struct packed {
    side_b_t             b;
    logic [NUMXY_W-1:0]  nx;
    logic [NUMXY_W-1:0]  ny;
    logic [NUMZ_W-1:0]   nz;
    logic [ABSZ_W-1:0]   cw;
    logic [19:0]         refn;
  } side_a_t;

  // Turns a magnitude quotient into the floor quotient of a signed numerator.
  function automatic logic signed [QS_W-1:0] signed_quot(
    input logic [DIV_QB-1:0] q,
    input logic              rem_nz,
    input logic              ovf,
    input logic              neg
  );
    logic [QS_W-1:0] mag;
    if (ovf) begin
      mag = QS_W'(1) << DIV_QB;
    end else begin
      mag = QS_W'(q) + ((neg && rem_nz) ? QS_W'(1) : QS_W'(0));
    end
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

  function automatic logic [SCR_W-1:0] sat_screen(input logic signed [QS_W-1:0] v);
    logic signed [QS_W-1:0] r;
    if (v > QS_W'(SCR_MAX)) begin
      r = QS_W'(SCR_MAX);
    end else if (v < QS_W'(SCR_MIN)) begin
      r = QS_W'(SCR_MIN);
    end else begin
      r = v;
    end
    return r[SCR_W-1:0];
  endfunction

  function automatic logic [DEPTH_W-1:0] sat_depth(input logic signed [QS_W-1:0] v);
    logic signed [QS_W-1:0] r;
    if (v > QS_W'(DEP_MAX)) begin
      r = QS_W'(DEP_MAX);
    end else if (v < QS_W'(DEP_MIN)) begin
      r = QS_W'(DEP_MIN);
    end else begin
      r = v;
    end
    return r[DEPTH_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/apvc_delay.sv */
// Enable-gated delay line for sideband data that rides beside a long unit.
`timescale 1ns / 1ps
`default_nettype none
module apvc_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic [W-1:0]      dout
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule
`default_nettype wire

/* rtl/core/apvc_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module apvc_sqrt
  import apvc_pkg::*;
#(
  parameter int VW = SQRT_IN_W
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [VW-1:0] v,
  output logic [VW/2-1:0]    root
);

  localparam int RW  = VW / 2;
  localparam int RMW = RW + 4;

  logic [VW-1:0]  vs [RW];
  logic [RMW-1:0] rs [RW];
  logic [RW-1:0]  qs [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [VW-1:0]  v_in;
    logic [RMW-1:0] r_in;
    logic [RW-1:0]  q_in;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;

    if (i == 0) begin : g_first
      assign v_in = v;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vs[i-1];
      assign r_in = rs[i-1];
      assign q_in = qs[i-1];
    end

    assign cur   = {r_in[RMW-3:0], v_in[VW-1 -: 2]};
    assign trial = RMW'({q_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        vs[i] <= v_in << 2;
        if (cur >= trial) begin
          rs[i] <= cur - trial;
          qs[i] <= {q_in[RW-2:0], 1'b1};
        end else begin
          rs[i] <= cur;
          qs[i] <= {q_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = qs[RW-1];

endmodule
`default_nettype wire

/* rtl/core/apvc_div.sv */
// Pipelined restoring divider with a range check stage, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module apvc_div #(
  parameter int NW = 40,
  parameter int DW = 29,
  parameter int QB = 23
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [QB-1:0]      quot,
  output logic               rem_nz,
  output logic               ovf
);

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic [CW-1:0] rm [QB+1];
  logic [DW-1:0] dv [QB+1];
  logic [QB-1:0] qt [QB+1];
  logic          ov [QB+1];

  // The quotient only fits when the numerator is below the divisor times 2^QB.
  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= CW'(num);
      dv[0] <= den;
      qt[0] <= '0;
      ov[0] <= CW'(num) >= (CW'(den) << QB);
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [CW-1:0] dsh;
    assign dsh = CW'(dv[i]) << (QB - 1 - i);

    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        ov[i+1] <= ov[i];
        if (rm[i] >= dsh) begin
          rm[i+1] <= rm[i] - dsh;
          qt[i+1] <= {qt[i][QB-2:0], 1'b1};
        end else begin
          rm[i+1] <= rm[i];
          qt[i+1] <= {qt[i][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign quot   = qt[QB];
  assign rem_nz = |rm[QB];
  assign ovf    = ov[QB];

endmodule
`default_nettype wire

/* rtl/core/anchor_projection_viewport_clamp_unit.sv */
// Top level of the anchor projection and viewport clamp pipeline.
// From an accepted request to its result lie four stages of transform and setup,
// 29 square-root stages, 24 divider stages and one output register.
// Throughput is one request per cycle; a stalled result freezes the whole pipeline.
// Reset is synchronous, clears the valid bits and sets the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none
module anchor_projection_viewport_clamp_unit
  import apvc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [WORLD_W-1:0] world_x,
  input  wire logic signed [WORLD_W-1:0] world_y,
  input  wire logic signed [WORLD_W-1:0] world_z,
  input  wire logic signed [15:0]        offset_x,
  input  wire logic signed [15:0]        offset_y,
  input  wire logic [3:0]                anchor_flags,
  input  wire logic [15:0]               safe_margin,
  input  wire logic [19:0]               reference_distance,
  input  wire logic [15:0]               min_scale,
  input  wire logic [15:0]               max_scale,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     anchor_state,
  output logic                           render,
  output logic signed [SCR_W-1:0]        screen_x,
  output logic signed [SCR_W-1:0]        screen_y,
  output logic signed [DEPTH_W-1:0]      ndc_depth,
  output logic [SCALE_W-1:0]             size_scale,
  input  wire logic                      cfg_write,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [ROW_W-1:0]          cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce this. Every stage reads them directly.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] clip_x_row, clip_y_row, clip_z_row, clip_w_row;
  logic [CAM_W-1:0] camera_position;
  logic [VP_W-1:0]  vp_width, vp_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_x_row      <= ROW_W'(4096);
      clip_y_row      <= ROW_W'(4096) << 16;
      clip_z_row      <= ROW_W'(4096) << 32;
      clip_w_row      <= ROW_W'(16) << 48;
      camera_position <= '0;
      vp_width        <= '0;
      vp_height       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CLIP_X:    clip_x_row      <= cfg_data;
        CFG_CLIP_Y:    clip_y_row      <= cfg_data;
        CFG_CLIP_Z:    clip_z_row      <= cfg_data;
        CFG_CLIP_W:    clip_w_row      <= cfg_data;
        CFG_CAMERA:    camera_position <= cfg_data[CAM_W-1:0];
        CFG_VP_WIDTH:  vp_width        <= cfg_data[VP_W-1:0];
        CFG_VP_HEIGHT: vp_height       <= cfg_data[VP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Every stage advances together; the pipeline holds only when
  // a finished result is waiting and the receiver stalls it.
  // ---------------------------------------------------------------------------
  logic [LATENCY-1:0] vld;
  logic               en;

  assign en        = !(vld[LATENCY-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the twelve matrix products, the translations and the squared
  // camera-to-anchor differences.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]          row  [4];
  logic signed [WORLD_W-1:0] wsel [3];
  logic signed [PROD_W-1:0]  prod [4][3];
  logic signed [TRANS_W-1:0] trans [4];
  logic signed [WORLD_W-1:0] cam  [3];
  logic signed [DIFF_W-1:0]  dxyz [3];
  logic signed [2*DIFF_W-1:0] sqf [3];
  fields_t                   f0;

  assign row[0]  = clip_x_row;
  assign row[1]  = clip_y_row;
  assign row[2]  = clip_z_row;
  assign row[3]  = clip_w_row;
  assign wsel[0] = world_x;
  assign wsel[1] = world_y;
  assign wsel[2] = world_z;

  assign f0.ox     = offset_x;
  assign f0.oy     = offset_y;
  assign f0.flags  = anchor_flags;
  assign f0.margin = safe_margin;
  assign f0.refd   = reference_distance;
  assign f0.s0     = min_scale;
  assign f0.s1     = max_scale;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] = PROD_W'($signed(row[r][COEF_W*k +: COEF_W])) * PROD_W'(wsel[k]);
      end
      trans[r] = $signed({row[r][63:48], 16'h0000});
    end
    for (int k = 0; k < 3; k++) begin
      cam[k]  = $signed(camera_position[WORLD_W*k +: WORLD_W]);
      dxyz[k] = DIFF_W'(wsel[k]) - DIFF_W'(cam[k]);
      sqf[k]  = (2*DIFF_W)'(dxyz[k]) * (2*DIFF_W)'(dxyz[k]);
    end
  end

  logic signed [PROD_W-1:0]  s1_prod  [4][3];
  logic signed [TRANS_W-1:0] s1_trans [4];
  logic [SQR_W-1:0]          s1_sq    [3];
  fields_t                   s1_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod  <= prod;
      s1_trans <= trans;
      for (int k = 0; k < 3; k++) begin
        s1_sq[k] <= sqf[k][SQR_W-1:0];
      end
      s1_f <= f0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: clip coordinates in Q.20 and the squared camera distance in Q.16.
  // ---------------------------------------------------------------------------
  logic signed [CLIP_W-1:0] s2_clip [4];
  logic [D2_W-1:0]          s2_d2;
  fields_t                  s2_f;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        s2_clip[r] <= CLIP_W'(s1_prod[r][0]) + CLIP_W'(s1_prod[r][1]) +
                      CLIP_W'(s1_prod[r][2]) + CLIP_W'(s1_trans[r]);
      end
      s2_d2 <= D2_W'(s1_sq[0]) + D2_W'(s1_sq[1]) + D2_W'(s1_sq[2]);
      s2_f  <= s1_f;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: classification, the cube test, and the magnitudes of the
  // numerators so the dividers only see unsigned values.
  // ---------------------------------------------------------------------------
  logic signed [CLIP_W:0] sum_x, sum_y;
  logic                   outside;
  ctl_t                   ctl3;
  logic [ABS_W-1:0]       ax3, ay3;
  logic [ABSZ_W-1:0]      az3;
  logic [15:0]            lo3, hi3;
  logic [19:0]            refn3;

  always_comb begin
    sum_x = (CLIP_W+1)'(s2_clip[0]) + (CLIP_W+1)'(s2_clip[3]);
    sum_y = (CLIP_W+1)'(s2_clip[1]) + (CLIP_W+1)'(s2_clip[3]);
    outside = ((CLIP_W+1)'(s2_clip[0]) < -(CLIP_W+1)'(s2_clip[3])) ||
              (s2_clip[0] > s2_clip[3]) ||
              ((CLIP_W+1)'(s2_clip[1]) < -(CLIP_W+1)'(s2_clip[3])) ||
              (s2_clip[1] > s2_clip[3]) ||
              (s2_clip[2] < 0) || (s2_clip[2] > s2_clip[3]);

    priority if (!s2_f.flags[FLAG_ENABLE]) begin
      ctl3.state = ST_DISABLED;
    end else if (vp_width == '0 || vp_height == '0) begin
      ctl3.state = ST_NO_CAMERA;
    end else if (s2_clip[3] <= 0) begin
      ctl3.state = ST_BEHIND;
    end else if (outside) begin
      ctl3.state = ST_OUTSIDE;
    end else begin
      ctl3.state = ST_VISIBLE;
    end

    unique case (ctl3.state)
      ST_BEHIND:  ctl3.render = !s2_f.flags[FLAG_HIDE_BEHIND];
      ST_OUTSIDE: ctl3.render = !s2_f.flags[FLAG_HIDE_OUT];
      ST_VISIBLE: ctl3.render = 1'b1;
      default:    ctl3.render = 1'b0;
    endcase

    ctl3.compute  = (ctl3.state == ST_OUTSIDE) || (ctl3.state == ST_VISIBLE);
    ctl3.clamp    = (ctl3.state == ST_OUTSIDE) && !s2_f.flags[FLAG_HIDE_OUT];
    ctl3.scale_en = ctl3.compute && ctl3.render && s2_f.flags[FLAG_SCALE];
    ctl3.negx     = sum_x[CLIP_W];
    ctl3.negy     = sum_y[CLIP_W];
    ctl3.negz     = s2_clip[2][CLIP_W-1];

    ax3 = ctl3.negx ? ABS_W'(-sum_x) : sum_x[ABS_W-1:0];
    ay3 = ctl3.negy ? ABS_W'(-sum_y) : sum_y[ABS_W-1:0];
    az3 = ctl3.negz ? ABSZ_W'(-s2_clip[2]) : s2_clip[2][ABSZ_W-1:0];

    lo3   = (s2_f.s0 < s2_f.s1) ? s2_f.s0 : s2_f.s1;
    hi3   = (s2_f.s0 < s2_f.s1) ? s2_f.s1 : s2_f.s0;
    refn3 = (s2_f.refd == '0) ? 20'd1 : s2_f.refd;
  end

  ctl_t              s3_ctl;
  logic [ABS_W-1:0]  s3_ax, s3_ay;
  logic [ABSZ_W-1:0] s3_az, s3_cw;
  logic [D2_W-1:0]   s3_d2;
  logic [15:0]       s3_lo, s3_hi;
  logic [19:0]       s3_refn;
  fields_t           s3_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctl  <= ctl3;
      s3_ax   <= ax3;
      s3_ay   <= ay3;
      s3_az   <= az3;
      s3_cw   <= s2_clip[3][ABSZ_W-1:0];
      s3_d2   <= s2_d2;
      s3_lo   <= lo3;
      s3_hi   <= hi3;
      s3_refn <= refn3;
      s3_f    <= s2_f;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: scale the x and y numerators by the viewport size, shift the depth
  // numerator, and work out the clamp upper edges, never below the margin.
  // ---------------------------------------------------------------------------
  side_a_t                  sa4;
  logic signed [EDGE_W-1:0] mg4, hxs, hys;

  always_comb begin
    mg4 = $signed({3'b000, s3_f.margin});
    hxs = $signed({1'b0, vp_width, 4'h0}) - mg4;
    hys = $signed({1'b0, vp_height, 4'h0}) - mg4;

    sa4.b.ctl    = s3_ctl;
    sa4.b.ox     = s3_f.ox;
    sa4.b.oy     = s3_f.oy;
    sa4.b.margin = s3_f.margin;
    sa4.b.hx     = (hxs < mg4) ? mg4 : hxs;
    sa4.b.hy     = (hys < mg4) ? mg4 : hys;
    sa4.b.lo     = s3_lo;
    sa4.b.hi     = s3_hi;
    sa4.nx       = NUMXY_W'(s3_ax) * NUMXY_W'({vp_width, 3'b000});
    sa4.ny       = NUMXY_W'(s3_ay) * NUMXY_W'({vp_height, 3'b000});
    sa4.nz       = {s3_az, 14'h0000};
    sa4.cw       = s3_cw;
    sa4.refn     = s3_refn;
  end

  side_a_t         s4;
  logic [D2_W-1:0] s4_d2;

  always_ff @(posedge clk) begin
    if (en) begin
      s4    <= sa4;
      s4_d2 <= s3_d2;
    end
  end

  // ---------------------------------------------------------------------------
  // Camera distance. The square root runs while the rest of the request rides
  // alongside it in a delay line of equal length.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] root;
  side_a_t           da;

  apvc_sqrt #(.VW(SQRT_IN_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .v    ({s4_d2, 16'h0000}),
    .root (root)
  );

  apvc_delay #(.W($bits(side_a_t)), .DEPTH(DIST_W)) u_dly_a (
    .clk  (clk),
    .en   (en),
    .din  (s4),
    .dout (da)
  );

  // ---------------------------------------------------------------------------
  // Four dividers in lockstep: screen x, screen y, depth and distance scale.
  // The distance is raised to about 0.001 before it divides the reference.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] cam_dist;
  assign cam_dist = (root < DIST_MIN) ? DIST_MIN : root;

  logic [DIV_QB-1:0] qx, qy, qz, qs;
  logic              rnx, rny, rnz, rns;
  logic              ovx, ovy, ovz, ovs;

  apvc_div #(.NW(NUMXY_W), .DW(ABSZ_W), .QB(DIV_QB)) u_div_x (
    .clk (clk), .en (en), .num (da.nx), .den (da.cw),
    .quot (qx), .rem_nz (rnx), .ovf (ovx)
  );

  apvc_div #(.NW(NUMXY_W), .DW(ABSZ_W), .QB(DIV_QB)) u_div_y (
    .clk (clk), .en (en), .num (da.ny), .den (da.cw),
    .quot (qy), .rem_nz (rny), .ovf (ovy)
  );

  apvc_div #(.NW(NUMZ_W), .DW(ABSZ_W), .QB(DIV_QB)) u_div_z (
    .clk (clk), .en (en), .num (da.nz), .den (da.cw),
    .quot (qz), .rem_nz (rnz), .ovf (ovz)
  );

  apvc_div #(.NW(NUMS_W), .DW(DIST_W), .QB(DIV_QB)) u_div_s (
    .clk (clk), .en (en), .num ({da.refn, 20'h00000}), .den (cam_dist),
    .quot (qs), .rem_nz (rns), .ovf (ovs)
  );

  side_b_t db;

  apvc_delay #(.W($bits(side_b_t)), .DEPTH(DIV_QB + 1)) u_dly_b (
    .clk  (clk),
    .en   (en),
    .din  (da.b),
    .dout (db)
  );

  // ---------------------------------------------------------------------------
  // Final stage: floor the quotients, add the offsets, clamp inside the safe
  // margin when the anchor is outside but still drawn, then saturate.
  // ---------------------------------------------------------------------------
  logic signed [QS_W-1:0]   fx, fy, fz, sxa, sya, mgq;
  logic [SCR_W-1:0]         sx_n, sy_n;
  logic [DEPTH_W-1:0]       dep_n;
  logic [SCALE_W-1:0]       scale_n;

  always_comb begin
    fx  = signed_quot(qx, rnx, ovx, db.ctl.negx);
    fy  = signed_quot(qy, rny, ovy, db.ctl.negy);
    fz  = signed_quot(qz, rnz, ovz, db.ctl.negz);
    mgq = QS_W'($signed({1'b0, db.margin}));
    sxa = fx + QS_W'(db.ox);
    sya = fy + QS_W'(db.oy);

    if (db.ctl.clamp) begin
      if (sxa < mgq) begin
        sxa = mgq;
      end else if (sxa > QS_W'(db.hx)) begin
        sxa = QS_W'(db.hx);
      end
      if (sya < mgq) begin
        sya = mgq;
      end else if (sya > QS_W'(db.hy)) begin
        sya = QS_W'(db.hy);
      end
    end

    if (db.ctl.compute) begin
      sx_n  = sat_screen(sxa);
      sy_n  = sat_screen(sya);
      dep_n = sat_depth(fz);
    end else begin
      sx_n  = '0;
      sy_n  = '0;
      dep_n = '0;
    end

    priority if (!db.ctl.scale_en) begin
      scale_n = SCALE_ONE;
    end else if (ovs || (qs > DIV_QB'(db.hi))) begin
      scale_n = db.hi;
    end else if (qs < DIV_QB'(db.lo)) begin
      scale_n = db.lo;
    end else begin
      scale_n = qs[SCALE_W-1:0];
    end
  end

  // The remainder of the scale division plays no part in the result.
  logic unused_rns;
  assign unused_rns = rns;

  always_ff @(posedge clk) begin
    if (en) begin
      anchor_state <= db.ctl.state;
      render       <= db.ctl.render;
      screen_x     <= sx_n;
      screen_y     <= sy_n;
      ndc_depth    <= dep_n;
      size_scale   <= scale_n;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/apvc_checker.sv */
// Port-level checks of the anchor projection block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module apvc_checker
  import apvc_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic signed [WORLD_W-1:0] world_x,
  input wire logic signed [WORLD_W-1:0] world_y,
  input wire logic signed [WORLD_W-1:0] world_z,
  input wire logic signed [15:0]        offset_x,
  input wire logic signed [15:0]        offset_y,
  input wire logic [3:0]                anchor_flags,
  input wire logic [15:0]               safe_margin,
  input wire logic [19:0]               reference_distance,
  input wire logic [15:0]               min_scale,
  input wire logic [15:0]               max_scale,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [2:0]                anchor_state,
  input wire logic                      render,
  input wire logic signed [SCR_W-1:0]   screen_x,
  input wire logic signed [SCR_W-1:0]   screen_y,
  input wire logic signed [DEPTH_W-1:0] ndc_depth,
  input wire logic [SCALE_W-1:0]        size_scale,
  input wire logic                      cfg_write,
  input wire logic [2:0]                cfg_index,
  input wire logic [63:0]               cfg_data
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(size_scale))
    else $error("stalled result changed");

  // Back-pressure reaches the input only while a result is held.
  a_stall_path: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the held result");

  // After reset the pipeline is empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Only a drawable class may ask to be rendered.
  a_render_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && render |->
      anchor_state == ST_BEHIND || anchor_state == ST_OUTSIDE || anchor_state == ST_VISIBLE)
    else $error("render set for a disabled or camera-less anchor");

  // Early returns carry the default placement.
  a_early_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (anchor_state == ST_DISABLED || anchor_state == ST_NO_CAMERA ||
                  anchor_state == ST_BEHIND) |->
      screen_x == '0 && screen_y == '0 && ndc_depth == '0 && size_scale == SCALE_ONE)
    else $error("early return with a non-default placement");

endmodule

bind anchor_projection_viewport_clamp_unit apvc_checker u_apvc_checker (.*);
`default_nettype wire

/* verif/tb_anchor_projection_viewport_clamp_unit.sv */
// Testbench for the anchor projection and viewport clamp unit, with a self-checking scoreboard.
`timescale 1ns / 1ps
module tb_anchor_projection_viewport_clamp_unit;
  import apvc_pkg::*;

  // One anchor request as it is presented on the input channel.
  typedef struct {
    logic signed [19:0] wx;
    logic signed [19:0] wy;
    logic signed [19:0] wz;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [3:0]         flags;
    logic [15:0]        margin;
    logic [19:0]        refd;
    logic [15:0]        s0;
    logic [15:0]        s1;
  } anchor_req_t;

  // One screen placement as it comes out of the block.
  typedef struct {
    anchor_state_t      state;
    logic               render;
    logic [SCR_W-1:0]   sx;
    logic [SCR_W-1:0]   sy;
    logic [DEPTH_W-1:0] depth;
    logic [SCALE_W-1:0] scale;
  } placement_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [WORLD_W-1:0] world_x;
  logic signed [WORLD_W-1:0] world_y;
  logic signed [WORLD_W-1:0] world_z;
  logic signed [15:0]        offset_x;
  logic signed [15:0]        offset_y;
  logic [3:0]                anchor_flags;
  logic [15:0]               safe_margin;
  logic [19:0]               reference_distance;
  logic [15:0]               min_scale;
  logic [15:0]               max_scale;
  logic                      out_valid;
  logic                      out_stall;
  logic [2:0]                anchor_state;
  logic                      render;
  logic signed [SCR_W-1:0]   screen_x;
  logic signed [SCR_W-1:0]   screen_y;
  logic signed [DEPTH_W-1:0] ndc_depth;
  logic [SCALE_W-1:0]        size_scale;
  logic                      cfg_write;
  logic [2:0]                cfg_index;
  logic [ROW_W-1:0]          cfg_data;

  // Shadow copy of the configuration registers used by the predictor.
  logic [63:0] clip_row [0:3];
  logic [59:0] cam_pos;
  logic [13:0] vp_w;
  logic [13:0] vp_h;

  placement_t pending_placements[$];
  int         mismatches;
  bit         quiet;      // When set, neither side idles.
  bit         long_hold;  // When set, the receiver holds off for a long stretch.

  anchor_projection_viewport_clamp_unit DUT (.*);

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard limit on the run in case the block hangs.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Integer square root, bit by bit, of a nonnegative value.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Quotient rounded toward minus infinity; the divisor is always positive here.
  function automatic longint div_floor(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One matrix row applied to a world point, in Q.20.
  function automatic longint clip_coord(logic [63:0] row, longint x, longint y, longint z);
    longint c0, c1, c2, t;
    c0 = longint'($signed(row[15:0]));
    c1 = longint'($signed(row[31:16]));
    c2 = longint'($signed(row[47:32]));
    t  = longint'($signed(row[63:48]));
    return c0 * x + c1 * y + c2 * z + t * 65536;
  endfunction

  // Works out the screen placement of one anchor under the current configuration.
  function automatic placement_t project_anchor(anchor_req_t a);
    placement_t p;
    longint x, y, z, cx, cy, cz, cw, sx, sy, dep, vw, vh, mg, hx, hy, dx, dy, dz;
    longint unsigned d2, cam_dist, q, lo, hi, rf;
    bit outside;
    p.state  = ST_DISABLED;
    p.render = 1'b0;
    p.scale  = SCALE_ONE;
    sx = 0;
    sy = 0;
    dep = 0;
    x = a.wx;
    y = a.wy;
    z = a.wz;
    if (!a.flags[FLAG_ENABLE]) begin
      p.state = ST_DISABLED;
    end else if (vp_w == 0 || vp_h == 0) begin
      p.state = ST_NO_CAMERA;
    end else begin
      cx = clip_coord(clip_row[0], x, y, z);
      cy = clip_coord(clip_row[1], x, y, z);
      cz = clip_coord(clip_row[2], x, y, z);
      cw = clip_coord(clip_row[3], x, y, z);
      if (cw <= 0) begin
        p.state  = ST_BEHIND;
        p.render = !a.flags[FLAG_HIDE_BEHIND];
      end else begin
        vw = vp_w;
        vh = vp_h;
        outside = cx < -cw || cx > cw || cy < -cw || cy > cw || cz < 0 || cz > cw;
        sx  = div_floor((cx + cw) * vw * 8, cw) + longint'(a.ox);
        sy  = div_floor((cy + cw) * vh * 8, cw) + longint'(a.oy);
        dep = clampl(div_floor(cz * 16384, cw), DEP_MIN, DEP_MAX);
        if (outside && a.flags[FLAG_HIDE_OUT]) begin
          p.state = ST_OUTSIDE;
        end else begin
          if (outside) begin
            // Clamp into the safe rectangle; a margin past the middle pins to the margin.
            mg = a.margin;
            hx = vw * 16 - mg;
            hy = vh * 16 - mg;
            if (hx < mg) hx = mg;
            if (hy < mg) hy = mg;
            sx = clampl(sx, mg, hx);
            sy = clampl(sy, mg, hy);
          end
          p.state  = outside ? ST_OUTSIDE : ST_VISIBLE;
          p.render = 1'b1;
          if (a.flags[FLAG_SCALE]) begin
            dx = x - longint'($signed(cam_pos[19:0]));
            dy = y - longint'($signed(cam_pos[39:20]));
            dz = z - longint'($signed(cam_pos[59:40]));
            d2 = dx * dx + dy * dy + dz * dz;
            cam_dist = int_sqrt(d2 << 16);
            if (cam_dist < 66) cam_dist = 66;
            rf = (a.refd == 0) ? 1 : a.refd;
            lo = (a.s0 < a.s1) ? a.s0 : a.s1;
            hi = (a.s0 < a.s1) ? a.s1 : a.s0;
            q = (rf << 20) / cam_dist;
            p.scale = SCALE_W'((q < lo) ? lo : ((q > hi) ? hi : q));
          end
        end
        sx = clampl(sx, SCR_MIN, SCR_MAX);
        sy = clampl(sy, SCR_MIN, SCR_MAX);
      end
    end
    p.sx    = sx[SCR_W-1:0];
    p.sy    = sy[SCR_W-1:0];
    p.depth = dep[DEPTH_W-1:0];
    return p;
  endfunction

  // Receiver: draws random stall lengths over and over, with long holds while long_hold is set.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 4);
      if (long_hold) n = 400;
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Scoreboard: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    placement_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_placements.size() == 0) begin
        $error("unexpected result: anchor_state %0d", anchor_state);
        mismatches++;
      end else begin
        e = pending_placements.pop_front();
        if (anchor_state !== e.state) begin
          $error("anchor_state expected %0d actual %0d", e.state, anchor_state);
          mismatches++;
        end
        if (render !== e.render) begin
          $error("render expected %0d actual %0d", e.render, render);
          mismatches++;
        end
        if (screen_x !== e.sx) begin
          $error("screen_x expected %0d actual %0d", $signed(e.sx), screen_x);
          mismatches++;
        end
        if (screen_y !== e.sy) begin
          $error("screen_y expected %0d actual %0d", $signed(e.sy), screen_y);
          mismatches++;
        end
        if (ndc_depth !== e.depth) begin
          $error("ndc_depth expected %0d actual %0d", $signed(e.depth), ndc_depth);
          mismatches++;
        end
        if (size_scale !== e.scale) begin
          $error("size_scale expected %0d actual %0d", e.scale, size_scale);
          mismatches++;
        end
      end
    end
  end

  // Offers one request, waits for it to be taken, then idles for a random gap.
  task automatic send_anchor(anchor_req_t a);
    int gap;
    in_valid           <= 1'b1;
    world_x            <= a.wx;
    world_y            <= a.wy;
    world_z            <= a.wz;
    offset_x           <= a.ox;
    offset_y           <= a.oy;
    anchor_flags       <= a.flags;
    safe_margin        <= a.margin;
    reference_distance <= a.refd;
    min_scale          <= a.s0;
    max_scale          <= a.s1;
    do @(posedge clk); while (in_stall);
    pending_placements.insert(pending_placements.size(), project_anchor(a));
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets the pipeline drain so that registers change only while it is idle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_CLIP_X:    clip_row[0] = data;
      CFG_CLIP_Y:    clip_row[1] = data;
      CFG_CLIP_Z:    clip_row[2] = data;
      CFG_CLIP_W:    clip_row[3] = data;
      CFG_CAMERA:    cam_pos = data[59:0];
      CFG_VP_WIDTH:  vp_w = data[13:0];
      CFG_VP_HEIGHT: vp_h = data[13:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [63:0] pack_row(int c0, int c1, int c2, int t);
    return {16'(t), 16'(c2), 16'(c1), 16'(c0)};
  endfunction

  // Identity transform with w = 1.0 and a 640 x 480 viewport.
  task automatic load_identity_setup();
    write_reg(CFG_CLIP_X, pack_row(4096, 0, 0, 0));
    write_reg(CFG_CLIP_Y, pack_row(0, 4096, 0, 0));
    write_reg(CFG_CLIP_Z, pack_row(0, 0, 4096, 0));
    write_reg(CFG_CLIP_W, pack_row(0, 0, 0, 16));
    write_reg(CFG_CAMERA, 64'd0);
    write_reg(CFG_VP_WIDTH, 64'd640);
    write_reg(CFG_VP_HEIGHT, 64'd480);
  endtask

  function automatic anchor_req_t make_anchor(int x, int y, int z, logic [3:0] flags);
    anchor_req_t a;
    a.wx = 20'(x);
    a.wy = 20'(y);
    a.wz = 20'(z);
    a.ox = 16'sd0;
    a.oy = 16'sd0;
    a.flags = flags;
    a.margin = 16'd64;
    a.refd = 20'd256;
    a.s0 = 16'd0;
    a.s1 = 16'hFFFF;
    return a;
  endfunction

  // Random anchor: mostly near the view volume so that every state is reached.
  function automatic anchor_req_t random_anchor();
    anchor_req_t a;
    if ($urandom_range(0, 9) < 7) begin
      a.wx = 20'($urandom_range(0, 640) - 320);
      a.wy = 20'($urandom_range(0, 640) - 320);
      a.wz = 20'($urandom_range(0, 320) - 30);
    end else begin
      a.wx = 20'($urandom);
      a.wy = 20'($urandom);
      a.wz = 20'($urandom);
    end
    a.ox = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512) - 256);
    a.oy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512) - 256);
    a.flags  = 4'($urandom);
    if ($urandom_range(0, 7) != 0) a.flags[FLAG_ENABLE] = 1'b1;
    a.margin = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800));
    a.refd   = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4096));
    a.s0     = 16'($urandom);
    a.s1     = 16'($urandom);
    return a;
  endfunction

  // Random register set: a perturbed perspective setup, or plain random bits.
  task automatic load_random_setup(bit wild);
    int j;
    if (wild) begin
      write_reg(CFG_CLIP_X, {$urandom, $urandom});
      write_reg(CFG_CLIP_Y, {$urandom, $urandom});
      write_reg(CFG_CLIP_Z, {$urandom, $urandom});
      write_reg(CFG_CLIP_W, {$urandom, $urandom});
    end else begin
      j = $urandom_range(0, 1024);
      write_reg(CFG_CLIP_X, pack_row(3584 + j, $urandom_range(0, 256) - 128,
                                     $urandom_range(0, 256) - 128, $urandom_range(0, 16) - 8));
      write_reg(CFG_CLIP_Y, pack_row($urandom_range(0, 256) - 128, 3584 + j,
                                     $urandom_range(0, 256) - 128, $urandom_range(0, 16) - 8));
      write_reg(CFG_CLIP_Z, pack_row(0, 0, 4096 - $urandom_range(0, 2048),
                                     $urandom_range(0, 8)));
      write_reg(CFG_CLIP_W, pack_row(0, 0, $urandom_range(0, 512) - 256,
                                     $urandom_range(8, 32)));
    end
    write_reg(CFG_CAMERA, {$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: write_reg(CFG_VP_WIDTH, 64'd16383);
      1: write_reg(CFG_VP_WIDTH, 64'd1);
      default: write_reg(CFG_VP_WIDTH, 64'($urandom_range(1, 4000)));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(CFG_VP_HEIGHT, 64'd16383);
      1: write_reg(CFG_VP_HEIGHT, 64'd1);
      default: write_reg(CFG_VP_HEIGHT, 64'($urandom_range(1, 4000)));
    endcase
  endtask

  // After reset the viewport is zero, so every enabled anchor reports no camera.
  task automatic test_reset_state();
    send_anchor(make_anchor(0, 0, 128, 4'b0001));
    send_anchor(make_anchor(0, 0, 128, 4'b0000));
    drain_pipeline();
  endtask

  // Directed anchors covering each state, the clamp, the scale and field extremes.
  task automatic test_directed_cases();
    anchor_req_t a;
    load_identity_setup();
    send_anchor(make_anchor(0, 0, 128, 4'b0001));             // centered and visible
    a = make_anchor(-524288, 524287, -524288, 4'b1110);       // disabled with extremes
    a.ox = 16'sh7FFF;
    a.oy = -16'sh8000;
    a.margin = 16'hFFFF;
    a.refd = 20'hFFFFF;
    send_anchor(a);
    send_anchor(make_anchor(512, 0, 128, 4'b0101));           // outside, hidden
    a = make_anchor(512, -700, 128, 4'b0001);                 // outside, clamped
    send_anchor(a);
    a.margin = 16'hFFFF;                                      // margin past the middle
    send_anchor(a);
    a = make_anchor(100, 50, -10, 4'b0001);                   // in front of the near plane
    a.ox = 16'sh7FFF;
    a.oy = -16'sh8000;
    send_anchor(a);
    send_anchor(make_anchor(524287, 524287, 524287, 4'b0001));
    send_anchor(make_anchor(-524288, -524288, 200, 4'b0101));
    a = make_anchor(20, 30, 128, 4'b1001);                    // distance scale
    send_anchor(a);
    a.refd = 20'd0;                                           // zero reference distance
    send_anchor(a);
    a = make_anchor(0, 0, 0, 4'b1001);                        // anchor at the camera
    a.refd = 20'hFFFFF;
    send_anchor(a);
    a.s0 = 16'd9000;                                          // bounds in reverse order
    a.s1 = 16'd100;
    send_anchor(a);
    a.wz = 20'sd200;
    a.refd = 20'd1;
    send_anchor(a);
    a = make_anchor(700, 0, 128, 4'b1011);                    // outside, clamped, scaled
    send_anchor(a);
    drain_pipeline();
    // w of minus one puts every anchor behind the camera.
    write_reg(CFG_CLIP_W, pack_row(0, 0, 0, -16));
    send_anchor(make_anchor(0, 0, 128, 4'b0001));
    send_anchor(make_anchor(0, 0, 128, 4'b0011));
    drain_pipeline();
    // w of exactly zero also counts as behind.
    write_reg(CFG_CLIP_W, pack_row(0, 0, 0, 0));
    send_anchor(make_anchor(5, 5, 5, 4'b1101));
    drain_pipeline();
    write_reg(CFG_CLIP_W, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF});
    send_anchor(make_anchor(524287, 524287, -524288, 4'b0001));
    send_anchor(make_anchor(-524288, -524288, 524287, 4'b1001));
    drain_pipeline();
    write_reg(CFG_VP_HEIGHT, 64'd0);
    load_identity_setup();
    write_reg(CFG_VP_HEIGHT, 64'd0);
    send_anchor(make_anchor(0, 0, 128, 4'b0001));             // height zero: no camera
    drain_pipeline();
  endtask

  // Random anchors across several register sets, including a quiet stretch.
  task automatic test_random_traffic();
    for (int s = 0; s < 8; s++) begin
      load_random_setup(s == 5 || s == 6);
      if (s == 7) write_reg(CFG_VP_WIDTH, 64'd0);
      quiet = (s == 2);
      repeat (52) send_anchor(random_anchor());
      quiet = 1'b0;
      drain_pipeline();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    load_identity_setup();
    long_hold = 1'b1;
    quiet = 1'b1;
    repeat (90) send_anchor(random_anchor());
    long_hold = 1'b0;
    quiet = 1'b0;
    repeat (20) send_anchor(random_anchor());
    drain_pipeline();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    world_x = '0;
    world_y = '0;
    world_z = '0;
    offset_x = '0;
    offset_y = '0;
    anchor_flags = '0;
    safe_margin = '0;
    reference_distance = '0;
    min_scale = '0;
    max_scale = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_CLIP_X;
    cfg_data = '0;
    mismatches = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    // Shadow registers start at the reset values of the block.
    clip_row[0] = pack_row(4096, 0, 0, 0);
    clip_row[1] = pack_row(0, 4096, 0, 0);
    clip_row[2] = pack_row(0, 0, 4096, 0);
    clip_row[3] = pack_row(0, 0, 0, 16);
    cam_pos = '0;
    vp_w = '0;
    vp_h = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_cases();
    test_random_traffic();
    test_backpressure();

    // Allow any stray result to show up before the verdict.
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_placements.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
